FILE: rtl/core/mrx_pkg.sv
package mrx_pkg;

  localparam int unsigned XLEN      = 32;
  localparam int unsigned REG_COUNT = 32;
  localparam int unsigned REG_AW    = 5;
  localparam int unsigned JIDX_W    = 30;

  localparam logic [XLEN-1:0] TEXT_BASE_RESET = 32'h0040_0000;
  localparam logic [XLEN-1:0] SVC_EXIT        = 32'd10;

  localparam logic [REG_AW-1:0] REG_ZERO = 5'd0;
  localparam logic [REG_AW-1:0] REG_V0   = 5'd2;
  localparam logic [REG_AW-1:0] REG_A0   = 5'd4;

  typedef enum logic [1:0] {
    CMD_EXEC  = 2'd0,
    CMD_WRITE = 2'd1,
    CMD_READ  = 2'd2
  } mrx_cmd_e;

  localparam logic [5:0] FN_SLL     = 6'h00;
  localparam logic [5:0] FN_SRL     = 6'h02;
  localparam logic [5:0] FN_JR      = 6'h08;
  localparam logic [5:0] FN_SYSCALL = 6'h0c;
  localparam logic [5:0] FN_ADD     = 6'h20;
  localparam logic [5:0] FN_ADDU    = 6'h21;
  localparam logic [5:0] FN_SUB     = 6'h22;
  localparam logic [5:0] FN_AND     = 6'h24;
  localparam logic [5:0] FN_OR      = 6'h25;
  localparam logic [5:0] FN_XOR     = 6'h26;
  localparam logic [5:0] FN_SLT     = 6'h2a;

  typedef struct packed {
    logic              en;
    logic [REG_AW-1:0] addr;
    logic [XLEN-1:0]   data;
  } mrx_wr_t;

  typedef struct packed {
    logic [XLEN-1:0]   read_value;
    logic              overflow;
    logic              unknown_func;
    logic              jump_taken;
    logic [JIDX_W-1:0] jump_index;
    logic              syscall_taken;
    logic [XLEN-1:0]   syscall_service;
    logic [XLEN-1:0]   syscall_arg;
    logic              exit_request;
  } mrx_result_t;

endpackage

FILE: rtl/core/mrx_if.sv
interface mrx_req_if;
  logic        valid;
  logic        ready;
  logic [1:0]  cmd;
  logic [31:0] instr_word;
  logic [4:0]  reg_index;
  logic [31:0] reg_value;

  modport source (output valid, cmd, instr_word, reg_index, reg_value, input ready);
  modport sink   (input valid, cmd, instr_word, reg_index, reg_value, output ready);
endinterface

interface mrx_rsp_if;
  logic        valid;
  logic        ready;
  logic [31:0] read_value;
  logic        overflow;
  logic        unknown_func;
  logic        jump_taken;
  logic [29:0] jump_index;
  logic        syscall_taken;
  logic [31:0] syscall_service;
  logic [31:0] syscall_arg;
  logic        exit_request;

  modport source (
    output valid, read_value, overflow, unknown_func, jump_taken, jump_index,
           syscall_taken, syscall_service, syscall_arg, exit_request,
    input  ready
  );
  modport sink (
    input  valid, read_value, overflow, unknown_func, jump_taken, jump_index,
           syscall_taken, syscall_service, syscall_arg, exit_request,
    output ready
  );
endinterface

FILE: rtl/core/mrx_regfile.sv
module mrx_regfile (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     rd_en,
  input  logic [4:0]               rd_addr_a,
  input  logic [4:0]               rd_addr_b,
  input  mrx_pkg::mrx_wr_t         wr,
  output logic [31:0]              rdata_a,
  output logic [31:0]              rdata_b
);
  import mrx_pkg::*;

  logic [XLEN-1:0]      mem [REG_COUNT];
  logic [REG_COUNT-1:0] vld;
  logic                 wr_ok;

  // register zero is never written, so its valid bit stays low and it reads zero
  assign wr_ok = wr.en && (wr.addr != REG_ZERO);

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (wr_ok) begin
      vld[wr.addr] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_ok) begin
      mem[wr.addr] <= wr.data;
    end
  end

  // read with write-through bypass for a write landing on the same edge
  always_ff @(posedge clk) begin
    if (rd_en) begin
      if (wr_ok && (wr.addr == rd_addr_a)) begin
        rdata_a <= wr.data;
      end else begin
        rdata_a <= vld[rd_addr_a] ? mem[rd_addr_a] : '0;
      end
      if (wr_ok && (wr.addr == rd_addr_b)) begin
        rdata_b <= wr.data;
      end else begin
        rdata_b <= vld[rd_addr_b] ? mem[rd_addr_b] : '0;
      end
    end
  end

endmodule

FILE: rtl/core/mrx_alu.sv
module mrx_alu (
  input  logic [1:0]          cmd,
  input  logic [31:0]         instr_word,
  input  logic [4:0]          reg_index,
  input  logic [31:0]         reg_value,
  input  logic [31:0]         op_a,
  input  logic [31:0]         op_b,
  input  logic [31:0]         text_base,
  output mrx_pkg::mrx_result_t res,
  output mrx_pkg::mrx_wr_t     wr
);
  import mrx_pkg::*;

  logic [5:0]      func;
  logic [4:0]      shamt;
  logic [4:0]      rd;
  logic [XLEN-1:0] sum;
  logic [XLEN-1:0] diff;
  logic [XLEN-1:0] jdiff;
  logic            add_ovf;
  logic            sub_ovf;

  assign func  = instr_word[5:0];
  assign shamt = instr_word[10:6];
  assign rd    = instr_word[15:11];
  assign sum   = op_a + op_b;
  assign diff  = op_a - op_b;
  assign jdiff = op_a - text_base;

  assign add_ovf = ~(op_a[31] ^ op_b[31]) & (sum[31] ^ op_a[31]);
  assign sub_ovf = (op_a[31] ^ op_b[31]) & (diff[31] ^ op_a[31]);

  always_comb begin
    res     = '0;
    wr      = '0;
    wr.addr = rd;
    case (cmd)
      CMD_EXEC: begin
        case (func)
          FN_ADD: begin
            res.overflow = add_ovf;
            wr.en        = ~add_ovf;
            wr.data      = sum;
          end
          FN_ADDU: begin
            wr.en   = 1'b1;
            wr.data = sum;
          end
          FN_SUB: begin
            res.overflow = sub_ovf;
            wr.en        = ~sub_ovf;
            wr.data      = diff;
          end
          FN_AND: begin
            wr.en   = 1'b1;
            wr.data = op_a & op_b;
          end
          FN_OR: begin
            wr.en   = 1'b1;
            wr.data = op_a | op_b;
          end
          FN_XOR: begin
            wr.en   = 1'b1;
            wr.data = op_a ^ op_b;
          end
          FN_SLT: begin
            wr.en   = 1'b1;
            wr.data = {{(XLEN-1){1'b0}}, ($signed(op_a) < $signed(op_b))};
          end
          FN_SRL: begin
            wr.en   = 1'b1;
            wr.data = op_b >> shamt;
          end
          FN_SLL: begin
            wr.en   = 1'b1;
            wr.data = op_b << shamt;
          end
          FN_SYSCALL: begin
            // operand ports were steered to v0 and a0 for this function
            res.syscall_taken   = 1'b1;
            res.syscall_service = op_a;
            res.syscall_arg     = op_b;
            res.exit_request    = (op_a == SVC_EXIT);
          end
          FN_JR: begin
            res.jump_taken = 1'b1;
            res.jump_index = jdiff[XLEN-1:2];
          end
          default: begin
            res.unknown_func = 1'b1;
          end
        endcase
      end
      CMD_WRITE: begin
        wr.en   = 1'b1;
        wr.addr = reg_index;
        wr.data = reg_value;
      end
      CMD_READ: begin
        res.read_value = op_a;
      end
      default: begin
        res = '0;
      end
    endcase
  end

endmodule

FILE: rtl/core/mips_rtype_execute_unit_core.sv
// MIPS32 R-format execute unit with a 32 x 32-bit register file.
//
// Channels: req carries one command per transaction (execute an R-format
// word, write a register, read a register); rsp returns exactly one result
// transaction per request, in order. Both use valid/ready; a transaction
// completes on a rising edge with valid and ready high. The user must load
// text_base through text_base_we / text_base_wdata only while the unit is
// idle; the block itself does not enforce it.
//
// Path: an accepted request is registered in the operand stage together with
// its register-file read; the ALU result is then registered in the result
// register that drives rsp. Throughput: one transaction per cycle while
// rsp.ready stays high, set by the single operand stage and the two-port
// register file read.
// Reset: pipeline empties, text_base returns to 0x00400000, and all
// registers read as zero (per-entry valid bits are cleared).
//
// Stall: while rsp is held off, the result register holds, the operand
// stage takes one more request, and then req.ready drops until rsp drains.
module mips_rtype_execute_unit_core (
  input  logic        clk,
  input  logic        rst,
  input  logic        text_base_we,
  input  logic [31:0] text_base_wdata,
  mrx_req_if.sink     req,
  mrx_rsp_if.source   rsp
);
  import mrx_pkg::*;

  // configuration
  logic [XLEN-1:0] text_base;

  // operand stage
  logic            s1_valid;
  logic [1:0]      s1_cmd;
  logic [XLEN-1:0] s1_instr;
  logic [REG_AW-1:0] s1_index;
  logic [XLEN-1:0] s1_value;

  // result stage
  logic        out_valid;
  mrx_result_t res;

  logic            in_take;
  logic            out_free;
  logic            s1_adv;
  logic            req_is_sys;
  logic [REG_AW-1:0] addr_a;
  logic [REG_AW-1:0] addr_b;
  logic [XLEN-1:0] op_a;
  logic [XLEN-1:0] op_b;
  mrx_result_t     alu_res;
  mrx_wr_t         alu_wr;
  mrx_wr_t         rf_wr;

  // advance the operand stage whenever the result register is free
  assign out_free  = !out_valid || rsp.ready;
  assign s1_adv    = s1_valid && out_free;
  assign req.ready = !s1_valid || out_free;
  assign in_take   = req.valid && req.ready;

  // steer read ports: a read command uses reg_index, syscall fetches v0/a0
  assign req_is_sys = (req.cmd == CMD_EXEC) && (req.instr_word[5:0] == FN_SYSCALL);

  always_comb begin
    if (req.cmd == CMD_READ) begin
      addr_a = req.reg_index;
    end else if (req_is_sys) begin
      addr_a = REG_V0;
    end else begin
      addr_a = req.instr_word[25:21];
    end
    addr_b = req_is_sys ? REG_A0 : req.instr_word[20:16];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      text_base <= TEXT_BASE_RESET;
    end else if (text_base_we) begin
      text_base <= text_base_wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_take) begin
      s1_valid <= 1'b1;
    end else if (s1_adv) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      s1_cmd   <= req.cmd;
      s1_instr <= req.instr_word;
      s1_index <= req.reg_index;
      s1_value <= req.reg_value;
    end
  end

  // commit the register write only on the edge the transaction leaves the stage
  always_comb begin
    rf_wr    = alu_wr;
    rf_wr.en = alu_wr.en && s1_adv;
  end

  mrx_regfile u_regfile (
    .clk       (clk),
    .rst       (rst),
    .rd_en     (in_take),
    .rd_addr_a (addr_a),
    .rd_addr_b (addr_b),
    .wr        (rf_wr),
    .rdata_a   (op_a),
    .rdata_b   (op_b)
  );

  mrx_alu u_alu (
    .cmd        (s1_cmd),
    .instr_word (s1_instr),
    .reg_index  (s1_index),
    .reg_value  (s1_value),
    .op_a       (op_a),
    .op_b       (op_b),
    .text_base  (text_base),
    .res        (alu_res),
    .wr         (alu_wr)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (s1_adv) begin
      out_valid <= 1'b1;
    end else if (rsp.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv) begin
      res <= alu_res;
    end
  end

  assign rsp.valid           = out_valid;
  assign rsp.read_value      = res.read_value;
  assign rsp.overflow        = res.overflow;
  assign rsp.unknown_func    = res.unknown_func;
  assign rsp.jump_taken      = res.jump_taken;
  assign rsp.jump_index      = res.jump_index;
  assign rsp.syscall_taken   = res.syscall_taken;
  assign rsp.syscall_service = res.syscall_service;
  assign rsp.syscall_arg     = res.syscall_arg;
  assign rsp.exit_request    = res.exit_request;

  // at most one instruction outcome per result
  a_outcome_onehot: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> $onehot0({res.overflow, res.unknown_func, res.jump_taken,
                            res.syscall_taken}))
    else $error("more than one instruction outcome flagged");

  a_exit_needs_sys: assert property (@(posedge clk) disable iff (rst)
    (out_valid && res.exit_request) |-> res.syscall_taken)
    else $error("exit without syscall");

  // a register write only happens as a transaction moves into the result stage
  a_write_on_adv: assert property (@(posedge clk) disable iff (rst)
    rf_wr.en |-> (s1_valid && out_free))
    else $error("register write outside stage advance");

  // an advancing operand stage always produces a result next cycle
  a_adv_gives_out: assert property (@(posedge clk) disable iff (rst)
    s1_adv |=> out_valid)
    else $error("advanced transaction lost");

  a_empty_ready: assert property (@(posedge clk) disable iff (rst)
    !s1_valid |-> req.ready)
    else $error("empty operand stage refused a request");

endmodule
